// ----- hw/rtl/tbs_pkg.sv -----
package tbs_pkg;

  // Width of every precomputed time target (ms); max is (65535+5)*1000
  localparam int unsigned TGT_W = 26;

  // Modes
  localparam logic [1:0] MODE_SYNC  = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_SLEEP = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_REARM  = 3'd1;
  localparam logic [2:0] ACT_ORPHAN = 3'd2;
  localparam logic [2:0] ACT_TX     = 3'd3;
  localparam logic [2:0] ACT_DEEP   = 3'd4;

  // Radio interrupt flag positions and beacon fields
  localparam int unsigned IRQ_RX_DONE = 6;
  localparam int unsigned IRQ_CRC_ERR = 5;
  localparam logic [7:0]  BEACON_CMD  = 8'd150;
  localparam logic [7:0]  DEST_BCAST  = 8'd0;

  // Timing constants
  localparam logic [TGT_W-1:0] MS_PER_S     = TGT_W'(1000);
  localparam logic [TGT_W-1:0] WAKE_LEAD_MS = TGT_W'(2000);
  localparam logic [TGT_W-1:0] ORPHAN_GUARD = TGT_W'(5000);

  // Reset values of the schedule state
  localparam logic [7:0]  RST_NODE  = 8'd20;
  localparam logic [15:0] RST_CYCLE = 16'd30;
  localparam logic [15:0] RST_SLOT  = 16'd300;

  // Divide by 1000 as multiply by reciprocal, exact for dividends below 2^26
  localparam int unsigned DIV_SHIFT = 36;
  localparam int unsigned DIV_MUL_W = 27;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 27'd68719477;

  // One registered input request
  typedef struct packed {
    logic        op;
    logic [15:0] elapsed_ms;
    logic [7:0]  irq_flags;
    logic [7:0]  rx_length;
    logic [7:0]  beacon_dest;
    logic [7:0]  beacon_command;
    logic [15:0] beacon_cycle_s;
    logic [15:0] beacon_slot_ms;
  } item_t;

  // Decision stage result, before the sleep seconds are worked out
  typedef struct packed {
    logic [2:0]       action;
    logic [TGT_W-1:0] rem_less_1s;
    logic [1:0]       mode_now;
    logic             synced;
  } decision_t;

endpackage

// ----- hw/rtl/tbs_if.sv -----
// Request channel into the scheduler
interface tbs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] elapsed_ms;
  logic [7:0]  irq_flags;
  logic [7:0]  rx_length;
  logic [7:0]  beacon_dest;
  logic [7:0]  beacon_command;
  logic [15:0] beacon_cycle_s;
  logic [15:0] beacon_slot_ms;

  modport source (
    output valid, op, elapsed_ms, irq_flags, rx_length, beacon_dest,
           beacon_command, beacon_cycle_s, beacon_slot_ms,
    input  ready
  );
  modport sink (
    input  valid, op, elapsed_ms, irq_flags, rx_length, beacon_dest,
           beacon_command, beacon_cycle_s, beacon_slot_ms,
    output ready
  );
endinterface

// Result channel out of the scheduler
interface tbs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] sleep_seconds;
  logic [1:0]  mode_now;
  logic        synced;

  modport source (
    output valid, action, sleep_seconds, mode_now, synced,
    input  ready
  );
  modport sink (
    input  valid, action, sleep_seconds, mode_now, synced,
    output ready
  );
endinterface

// ----- hw/rtl/tbs_div1000.sv -----
module tbs_div1000 (
  input  logic [tbs_pkg::TGT_W-1:0] dividend,
  output logic [15:0]               quotient
);
  import tbs_pkg::*;

  localparam int unsigned PROD_W = TGT_W + DIV_MUL_W;

  logic [PROD_W-1:0] product;

  // floor(dividend / 1000) by reciprocal multiply and shift
  assign product  = PROD_W'(dividend) * PROD_W'(DIV_MUL);
  assign quotient = product[DIV_SHIFT+15:DIV_SHIFT];

endmodule

// ----- hw/rtl/tdma_beacon_slot_scheduler.sv -----
// Slot scheduler of a beacon-synchronised TDMA node. A request passes the input register,
// decision stage and result register; the stages stall together only as far as the result side
// holds them, and otherwise one request is taken per clock. The loop that sets the rate is the
// decision stage, which reads and updates mode and the millisecond counter as its request moves
// on, so each request sees the state its predecessor left. Transmit, wake and orphan targets
// are kept in registers, recomputed whenever node number, cycle or slot change, and deep-sleep
// seconds come from a reciprocal multiplier in the last stage. The user writes node_number
// through cfg_write/cfg_data only while no request is in flight; the block does not enforce it.
module tdma_beacon_slot_scheduler #(
  parameter int unsigned ORPHAN_SLEEP_S = 300,
  parameter int unsigned BEACON_BYTES   = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic [7:0] cfg_data,
  tbs_in_if.sink    items,
  tbs_out_if.source results
);
  import tbs_pkg::*;

  localparam logic [15:0] ORPHAN_S   = 16'(ORPHAN_SLEEP_S);
  localparam logic [7:0]  BEACON_LEN = 8'(BEACON_BYTES);
  localparam logic [TGT_W-1:0] RST_TX_TGT  = TGT_W'((RST_NODE - 8'd1) * RST_SLOT);
  localparam logic [TGT_W-1:0] RST_SLP_TGT = TGT_W'(RST_CYCLE * 16'd1000 - 16'd2000);
  localparam logic [TGT_W-1:0] RST_ORP_LIM = TGT_W'((RST_CYCLE + 16'd5) * 16'd1000);

  // Schedule state
  logic [7:0]       node_number;
  logic [1:0]       mode, mode_next;
  logic [31:0]      ms_counter, counter_next;
  logic [15:0]      cycle_seconds;
  logic [15:0]      slot_length_ms;
  logic [TGT_W-1:0] tx_target, sleep_target, orphan_limit;

  // Pipeline registers
  logic      s0_valid;
  item_t     s0;
  logic      s1_valid;
  decision_t s1, s1_next;
  logic      out_valid;
  logic [2:0]  res_action;
  logic [15:0] res_sleep_seconds;
  logic [1:0]  res_mode_now;
  logic        res_synced;

  logic s0_free, s1_free, s2_free, take_in, proc, move;

  // Stall chain: each stage loads when it is empty or its content moves on
  assign s2_free = !out_valid || results.ready;
  assign s1_free = !s1_valid || s2_free;
  assign s0_free = !s0_valid || s1_free;
  assign take_in = items.valid && s0_free;
  assign proc    = s0_valid && s1_free;
  assign move    = s1_valid && s2_free;
  assign items.ready = s0_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_free) begin
      s0_valid <= items.valid;
    end
    if (take_in) begin
      s0 <= '{op: items.op, elapsed_ms: items.elapsed_ms, irq_flags: items.irq_flags,
              rx_length: items.rx_length, beacon_dest: items.beacon_dest,
              beacon_command: items.beacon_command, beacon_cycle_s: items.beacon_cycle_s,
              beacon_slot_ms: items.beacon_slot_ms};
    end
  end

  // Decision stage
  logic             is_sync, beacon_ok, load;
  logic [32:0]      sum;
  logic [31:0]      counter_add;
  logic [TGT_W-1:0] target_sel, remain;
  logic             reached, deep, over;
  logic [2:0]       act;
  logic             syn;

  assign is_sync   = (mode != MODE_WAIT) && (mode != MODE_SLEEP);
  assign beacon_ok = s0.irq_flags[IRQ_RX_DONE] && !s0.irq_flags[IRQ_CRC_ERR] &&
                     (s0.rx_length == BEACON_LEN) && (s0.beacon_dest == DEST_BCAST) &&
                     (s0.beacon_command == BEACON_CMD);
  assign load      = proc && s0.op && is_sync && beacon_ok;

  // Saturating counter advance
  assign sum         = {1'b0, ms_counter} + 33'(s0.elapsed_ms);
  assign counter_add = sum[32] ? '1 : sum[31:0];

  // Compare against the active target; remain only matters below it
  assign target_sel = (mode == MODE_WAIT) ? tx_target : sleep_target;
  assign reached    = counter_add >= 32'(target_sel);
  assign remain     = target_sel - counter_add[TGT_W-1:0];
  assign deep       = remain >= WAKE_LEAD_MS;
  assign over       = counter_add > 32'(orphan_limit);

  always_comb begin
    mode_next    = mode;
    counter_next = ms_counter;
    act          = ACT_NONE;
    syn          = 1'b0;
    if (s0.op) begin
      // receive event: only heard in sync mode
      if (is_sync) begin
        act = ACT_REARM;
        if (beacon_ok) begin
          mode_next    = MODE_WAIT;
          counter_next = '0;
          syn          = 1'b1;
        end
      end
    end else begin
      counter_next = counter_add;
      case (mode)
        MODE_WAIT: begin
          if (reached) begin
            act       = ACT_TX;
            mode_next = MODE_SLEEP;
          end else if (deep) begin
            act = ACT_DEEP;
          end
        end
        MODE_SLEEP: begin
          if (reached) begin
            act       = ACT_REARM;
            mode_next = MODE_SYNC;
          end else if (deep) begin
            act = ACT_DEEP;
          end
        end
        default: begin
          // sync, and the unused code, which falls back to sync
          mode_next = MODE_SYNC;
          if (over) begin
            act          = ACT_ORPHAN;
            counter_next = '0;
          end
        end
      endcase
    end
    s1_next = '{action: act, rem_less_1s: remain - MS_PER_S, mode_now: mode_next,
                synced: syn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s0_valid;
    end
    if (proc) begin
      s1 <= s1_next;
    end
  end

  // State update; targets follow the values they are built from in the same edge
  logic [7:0]       node_sel, node_m1;
  logic [15:0]      slot_sel, cyc_sel;
  logic [23:0]      tx_prod;
  logic [TGT_W-1:0] cyc_ms;

  assign node_sel = cfg_write ? cfg_data : node_number;
  assign node_m1  = node_sel - 8'd1;
  assign slot_sel = load ? s0.beacon_slot_ms : slot_length_ms;
  assign cyc_sel  = load ? s0.beacon_cycle_s : cycle_seconds;
  assign tx_prod  = 24'(node_m1) * 24'(slot_sel);
  assign cyc_ms   = TGT_W'(cyc_sel) * MS_PER_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_number    <= RST_NODE;
      mode           <= MODE_SYNC;
      ms_counter     <= '0;
      cycle_seconds  <= RST_CYCLE;
      slot_length_ms <= RST_SLOT;
      tx_target      <= RST_TX_TGT;
      sleep_target   <= RST_SLP_TGT;
      orphan_limit   <= RST_ORP_LIM;
    end else begin
      if (cfg_write) begin
        node_number <= cfg_data;
      end
      if (proc) begin
        mode       <= mode_next;
        ms_counter <= counter_next;
      end
      if (load) begin
        cycle_seconds  <= s0.beacon_cycle_s;
        slot_length_ms <= s0.beacon_slot_ms;
      end
      tx_target    <= TGT_W'(tx_prod);
      sleep_target <= (cyc_ms >= WAKE_LEAD_MS) ? cyc_ms - WAKE_LEAD_MS : '0;
      orphan_limit <= cyc_ms + ORPHAN_GUARD;
    end
  end

  // Result stage: sleep seconds
  logic [15:0] deep_s, secs;

  tbs_div1000 u_div (
    .dividend (s1.rem_less_1s),
    .quotient (deep_s)
  );

  always_comb begin
    case (s1.action)
      ACT_DEEP:   secs = deep_s;
      ACT_ORPHAN: secs = ORPHAN_S;
      default:    secs = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
    if (move) begin
      res_action        <= s1.action;
      res_sleep_seconds <= secs;
      res_mode_now      <= s1.mode_now;
      res_synced        <= s1.synced;
    end
  end

  assign results.valid         = out_valid;
  assign results.action        = res_action;
  assign results.sleep_seconds = res_sleep_seconds;
  assign results.mode_now      = res_mode_now;
  assign results.synced        = res_synced;

`ifndef SYNTHESIS
  // a beacon always leaves the node waiting for its slot
  a_sync_to_wait: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.synced |-> results.mode_now == MODE_WAIT)
    else $error("synced result not in wait mode");

  // seconds only accompany the two sleep actions
  a_secs_only_sleep: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.action != ACT_DEEP && results.action != ACT_ORPHAN
    |-> results.sleep_seconds == 16'd0)
    else $error("sleep seconds on non-sleep action");

  // transmit target register tracks node number and slot length; node zero wraps in 8 bits
  a_tx_target: assert property (@(posedge clk) disable iff (rst)
    tx_target == TGT_W'(24'(8'(node_number - 8'd1)) * 24'(slot_length_ms)))
    else $error("transmit target out of step");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tbs_pkg::*;

  localparam int unsigned ORPHAN_S   = 300;
  localparam int unsigned BEACON_LEN = 6;

  localparam logic [31:0] MS_PER_SEC      = 32'd1000;
  localparam logic [31:0] WAKE_MARGIN     = 32'd2000;
  localparam logic [31:0] ORPHAN_MARGIN_S = 32'd5;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Scheduler state and one result, at the block's widths
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ms;
    logic [15:0] cycle_s;
    logic [15:0] slot_ms;
  } sched_st_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] sleep_s;
    logic [1:0]  mode;
    logic        synced;
  } sched_res_t;

  typedef struct packed {
    sched_st_t  st;
    sched_res_t res;
  } sched_step_t;

  // Ways of spoiling an otherwise good beacon
  typedef enum int {
    SPOIL_RX_DONE,
    SPOIL_CRC,
    SPOIL_LEN,
    SPOIL_DEST,
    SPOIL_CMD
  } spoil_e;

  localparam sched_st_t SCHED_RESET = {MODE_SYNC, 32'd0, RST_CYCLE, RST_SLOT};

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic [7:0] node_cfg = RST_NODE;

  logic  in_valid = 1'b0;
  item_t in_item = '0;
  logic  out_ready = 1'b0;

  item_t      pending_q[$];
  sched_res_t expect_q[$];
  sched_st_t  dut_st = SCHED_RESET;
  sched_st_t  plan_st = SCHED_RESET;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  tbs_in_if  req_if ();
  tbs_out_if res_if ();

  assign req_if.valid          = in_valid;
  assign req_if.op             = in_item.op;
  assign req_if.elapsed_ms     = in_item.elapsed_ms;
  assign req_if.irq_flags      = in_item.irq_flags;
  assign req_if.rx_length      = in_item.rx_length;
  assign req_if.beacon_dest    = in_item.beacon_dest;
  assign req_if.beacon_command = in_item.beacon_command;
  assign req_if.beacon_cycle_s = in_item.beacon_cycle_s;
  assign req_if.beacon_slot_ms = in_item.beacon_slot_ms;
  assign res_if.ready          = out_ready;

  tdma_beacon_slot_scheduler #(
    .ORPHAN_SLEEP_S (ORPHAN_S),
    .BEACON_BYTES   (BEACON_LEN)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .items     (req_if),
    .results   (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Next scheduler state and the result one request gives
  function automatic sched_step_t sched_next(input sched_st_t cur, input logic [7:0] node,
                                             input item_t it);
    sched_step_t nx;
    logic [32:0] sum;
    logic [7:0]  node_m1;
    logic [31:0] full_ms;
    logic [31:0] target;
    logic [31:0] remain;
    nx.st = cur;
    nx.res = '0;
    nx.res.action = ACT_NONE;
    if (it.op) begin
      // receive events only count in sync mode
      if (cur.mode != MODE_WAIT && cur.mode != MODE_SLEEP) begin
        nx.res.action = ACT_REARM;
        if (it.irq_flags[IRQ_RX_DONE] && !it.irq_flags[IRQ_CRC_ERR] &&
            it.rx_length == 8'(BEACON_LEN) && it.beacon_dest == DEST_BCAST &&
            it.beacon_command == BEACON_CMD) begin
          nx.st.mode = MODE_WAIT;
          nx.st.ms = '0;
          nx.st.cycle_s = it.beacon_cycle_s;
          nx.st.slot_ms = it.beacon_slot_ms;
          nx.res.synced = 1'b1;
        end
      end
    end else begin
      // saturating millisecond count
      sum = {1'b0, cur.ms} + {17'd0, it.elapsed_ms};
      nx.st.ms = sum[32] ? '1 : sum[31:0];
      if (cur.mode == MODE_WAIT || cur.mode == MODE_SLEEP) begin
        node_m1 = node - 8'd1;
        full_ms = {16'd0, cur.cycle_s} * MS_PER_SEC;
        if (cur.mode == MODE_WAIT) begin
          target = {24'd0, node_m1} * {16'd0, cur.slot_ms};
        end else begin
          target = (full_ms >= WAKE_MARGIN) ? full_ms - WAKE_MARGIN : '0;
        end
        if (nx.st.ms >= target) begin
          nx.res.action = (cur.mode == MODE_WAIT) ? ACT_TX : ACT_REARM;
          nx.st.mode = (cur.mode == MODE_WAIT) ? MODE_SLEEP : MODE_SYNC;
        end else begin
          // long waits go to deep sleep; the count is left alone
          remain = target - nx.st.ms;
          if (remain >= WAKE_MARGIN) begin
            nx.res.action = ACT_DEEP;
            nx.res.sleep_s = 16'(remain / MS_PER_SEC - 32'd1);
          end
        end
      end else begin
        nx.st.mode = MODE_SYNC;
        if (nx.st.ms > ({16'd0, cur.cycle_s} + ORPHAN_MARGIN_S) * MS_PER_SEC) begin
          nx.res.action = ACT_ORPHAN;
          nx.res.sleep_s = 16'(ORPHAN_S);
          nx.st.ms = '0;
        end
      end
    end
    nx.res.mode = nx.st.mode;
    return nx;
  endfunction

  // Request builders
  function automatic item_t rand_item(input logic op);
    item_t it;
    it.op = op;
    it.elapsed_ms = 16'($urandom);
    it.irq_flags = 8'($urandom);
    it.rx_length = 8'($urandom);
    it.beacon_dest = 8'($urandom);
    it.beacon_command = 8'($urandom);
    it.beacon_cycle_s = 16'($urandom);
    it.beacon_slot_ms = 16'($urandom);
    return it;
  endfunction

  function automatic item_t tick_of(input logic [15:0] ms);
    item_t it;
    it = rand_item(1'b0);
    it.elapsed_ms = ms;
    return it;
  endfunction

  function automatic item_t beacon_of(input logic [15:0] cyc, input logic [15:0] slot);
    item_t it;
    it = rand_item(1'b1);
    it.irq_flags[IRQ_RX_DONE] = 1'b1;
    it.irq_flags[IRQ_CRC_ERR] = 1'b0;
    it.rx_length = 8'(BEACON_LEN);
    it.beacon_dest = DEST_BCAST;
    it.beacon_command = BEACON_CMD;
    it.beacon_cycle_s = cyc;
    it.beacon_slot_ms = slot;
    return it;
  endfunction

  // Mostly short cycles and slots so that a full round takes a handful of ticks
  function automatic item_t rand_beacon();
    int roll;
    logic [15:0] cyc;
    logic [15:0] slot;
    roll = $urandom_range(99);
    if (roll < 10) cyc = 16'($urandom_range(2));
    else if (roll < 88) cyc = 16'($urandom_range(40, 3));
    else cyc = 16'($urandom_range(400, 41));
    roll = $urandom_range(99);
    if (roll < 10) slot = '0;
    else if (roll < 88) slot = 16'($urandom_range(1500, 1));
    else if (roll < 99) slot = 16'($urandom_range(8000, 1501));
    else slot = 16'($urandom_range(30000, 8001));
    return beacon_of(cyc, slot);
  endfunction

  function automatic item_t spoil(input item_t b, input spoil_e how);
    item_t it;
    it = b;
    case (how)
      SPOIL_RX_DONE: it.irq_flags[IRQ_RX_DONE] = 1'b0;
      SPOIL_CRC:     it.irq_flags[IRQ_CRC_ERR] = 1'b1;
      SPOIL_LEN: begin
        it.rx_length = 8'($urandom);
        if (it.rx_length == 8'(BEACON_LEN)) it.rx_length = 8'(BEACON_LEN + 1);
      end
      SPOIL_DEST: it.beacon_dest = 8'($urandom_range(255, 1));
      default: begin
        it.beacon_command = 8'($urandom);
        if (it.beacon_command == BEACON_CMD) it.beacon_command = BEACON_CMD + 8'd1;
      end
    endcase
    return it;
  endfunction

  // Tick length; far from the target most ticks are long
  function automatic logic [15:0] pick_ms(input bit far);
    int roll;
    roll = $urandom_range(99);
    if (far && roll < 85) return 16'($urandom_range(65535, 30000));
    if (roll < 40) return 16'($urandom_range(2500));
    if (roll < 80) return 16'($urandom_range(20000));
    if (roll < 95) return 16'($urandom_range(65534, 20001));
    return 16'hFFFF;
  endfunction

  task automatic queue_item(input item_t it);
    sched_step_t nx;
    nx = sched_next(plan_st, node_cfg, it);
    plan_st = nx.st;
    pending_q.push_back(it);
  endtask

  // Random traffic steered by the planned state: mostly beacons while in sync, mostly ticks otherwise
  task automatic queue_random(input int count);
    int made;
    int roll;
    item_t it;
    sched_step_t probe;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      if (plan_st.mode == MODE_WAIT || plan_st.mode == MODE_SLEEP) begin
        if (roll < 12) begin
          it = rand_item(1'b1);
        end else begin
          probe = sched_next(plan_st, node_cfg, tick_of(16'd0));
          it = tick_of(pick_ms(probe.res.action == ACT_DEEP && probe.res.sleep_s > 16'd60));
          made++;
        end
      end else begin
        if (roll < 45) it = rand_beacon();
        else if (roll < 60) it = spoil(rand_beacon(), spoil_e'($urandom_range(4)));
        else if (roll < 68) it = rand_item(1'b1);
        else it = tick_of(pick_ms(1'b0));
        made++;
      end
      queue_item(it);
    end
  endtask

  // Wait until no request is queued, offered or awaiting its result
  task automatic drain();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_node(input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    node_cfg = val;
  endtask

  task automatic run_random(input logic [7:0] node, input int send_idle, input int stall,
                            input int count, input bit squeeze);
    send_idle_pct = send_idle;
    stall_pct = stall;
    write_node(node);
    @(negedge clk);
    if (squeeze) hold_go <= 1'b1;
    queue_random(count);
    drain();
  endtask

  // Request driver: predicts on acceptance, then offers the next queued request
  always @(posedge clk) begin
    sched_step_t nx;
    if (rst) begin
      in_valid <= 1'b0;
      dut_st = SCHED_RESET;
    end else begin
      if (in_valid && req_if.ready) begin
        nx = sched_next(dut_st, node_cfg, in_item);
        dut_st = nx.st;
        expect_q.push_back(nx.res);
      end
      if (!in_valid || req_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    sched_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (res_if.valid && out_ready) begin
        if (expect_q.size() == 0) begin
          $error("result with nothing pending: action %0d", res_if.action);
          fail_cnt++;
        end else begin
          want = expect_q.pop_front();
          if (res_if.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, res_if.action);
            fail_cnt++;
          end
          if (res_if.sleep_seconds !== want.sleep_s) begin
            $error("sleep_seconds: expected %0d, got %0d", want.sleep_s, res_if.sleep_seconds);
            fail_cnt++;
          end
          if (res_if.mode_now !== want.mode) begin
            $error("mode_now: expected %0d, got %0d", want.mode, res_if.mode_now);
            fail_cnt++;
          end
          if (res_if.synced !== want.synced) begin
            $error("synced: expected %0d, got %0d", want.synced, res_if.synced);
            fail_cnt++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: beacon checks, orphan edge, zero-length schedule, deep-sleep edges
    queue_item(tick_of(16'd0));
    queue_item(spoil(beacon_of(16'd30, 16'd300), SPOIL_CRC));
    queue_item(spoil(beacon_of(16'd30, 16'd300), SPOIL_RX_DONE));
    queue_item(spoil(beacon_of(16'd30, 16'd300), SPOIL_LEN));
    queue_item(spoil(beacon_of(16'd30, 16'd300), SPOIL_DEST));
    queue_item(spoil(beacon_of(16'd30, 16'd300), SPOIL_CMD));
    queue_item(tick_of(16'd35000));
    queue_item(tick_of(16'd1));
    queue_item(beacon_of(16'd0, 16'd0));
    queue_item(rand_item(1'b1));
    queue_item(tick_of(16'd0));
    queue_item(rand_item(1'b1));
    queue_item(tick_of(16'd0));
    queue_item(beacon_of(16'd1, 16'd3000));
    queue_item(tick_of(16'd10000));
    queue_item(tick_of(16'd45000));
    queue_item(tick_of(16'd1));
    queue_item(tick_of(16'd1999));
    queue_item(tick_of(16'd0));
    queue_item(tick_of(16'hFFFF));
    drain();

    // Node zero wraps to the last slot
    write_node(8'd0);
    @(negedge clk);
    queue_item(beacon_of(16'd2, 16'd10));
    queue_item(tick_of(16'd0));
    queue_item(tick_of(16'd2550));
    queue_item(tick_of(16'd0));
    drain();

    // Largest slot and a long cycle: first slot, then a long sleep worked off in big ticks
    write_node(8'd1);
    @(negedge clk);
    queue_item(beacon_of(16'd2000, 16'hFFFF));
    queue_item(tick_of(16'hFFFF));
    while (plan_st.mode != MODE_SYNC) queue_item(tick_of(16'($urandom_range(65535, 50000))));
    drain();

    run_random(8'd255, 0, 0, 300, 1'b1);
    run_random(8'($urandom_range(254, 2)), 82, 0, 300, 1'b0);
    run_random(RST_NODE, 0, 82, 300, 1'b0);
    run_random(8'($urandom_range(255, 1)), 34, 34, 300, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
